/* hdl/chained_hash_map_engine_top_assert.svh */
// ----------------------------------------------------------------------------
// Chained hash map engine assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_ENGINE_TOP_ASSERT_SVH
`define CHAINED_HASH_MAP_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, reset masked
`define CHME_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked
`define CHME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/chme_pkg.sv */
// ----------------------------------------------------------------------------
// Chained hash map engine package
// Sizes, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package chme_pkg;

    localparam int MAX_BUCKETS  = 256;
    localparam int POOL_ENTRIES = 512;
    localparam int BKT_W        = $clog2(MAX_BUCKETS);
    localparam int ENTRY_W      = $clog2(POOL_ENTRIES);
    localparam int LINK_W       = ENTRY_W + 1;
    localparam int CFG_W        = 9;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_ENTRIES);

    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam int          MIX_SHIFT = 33;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_PRESENT   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_ZERO      = 3'd4;

    localparam logic [1:0] MUL_LL = 2'd0;
    localparam logic [1:0] MUL_HL = 2'd1;
    localparam logic [1:0] MUL_LH = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mix;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       cst_sel;
        logic       acc_load;
        logic       acc_add;
        logic       x_from_acc;
        logic       div_step;
        logic       head_load;
        logic       advance;
        logic       hit;
        logic       commit;
    } chme_cmd_t;

    typedef struct packed {
        logic cur_null;
        logic key_match;
        logic out_free;
    } chme_sts_t;

endpackage

/* hdl/chme_if.sv */
// ----------------------------------------------------------------------------
// Chained hash map engine channels
// Request and response valid/ready channels.
// ----------------------------------------------------------------------------
interface chme_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] key;
    logic [31:0] value_in;

    modport source (output valid, opcode, key, value_in, input ready);
    modport sink   (input valid, opcode, key, value_in, output ready);
endinterface

interface chme_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] value_out;
    logic [9:0]  entries_held;

    modport source (output valid, status, value_out, entries_held, input ready);
    modport sink   (input valid, status, value_out, entries_held, output ready);
endinterface

/* hdl/chme_ram.sv */
// ----------------------------------------------------------------------------
// Chained hash map engine RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/chme_ctrl.sv */
// ----------------------------------------------------------------------------
// Chained hash map engine controller
// Sequences hashing, bucket modulo, chain walk and commit.
// ----------------------------------------------------------------------------
module chme_ctrl
    import chme_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  chme_sts_t sts,
    output chme_cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MIX   = 4'd1;
    localparam logic [3:0] S_M0    = 4'd2;
    localparam logic [3:0] S_M1    = 4'd3;
    localparam logic [3:0] S_M2    = 4'd4;
    localparam logic [3:0] S_M3    = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_HEAD  = 4'd7;
    localparam logic [3:0] S_HLOAD = 4'd8;
    localparam logic [3:0] S_WRD   = 4'd9;
    localparam logic [3:0] S_WCMP  = 4'd10;
    localparam logic [3:0] S_DO    = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [1:0] pass_reg, pass_next;
    logic [3:0] cnt_reg, cnt_next;

    assign req_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.cst_sel = pass_reg[0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    pass_next  = 2'd0;
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                cmd.mix = 1'b1;
                if (pass_reg == 2'd2)
                begin
                    cnt_next   = 4'd0;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_M0;
                end
            end
            S_M0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LL;
                state_next  = S_M1;
            end
            S_M1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_HL;
                cmd.acc_load = 1'b1;
                state_next   = S_M2;
            end
            S_M2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LH;
                cmd.acc_add = 1'b1;
                state_next  = S_M3;
            end
            S_M3:
            begin
                cmd.x_from_acc = 1'b1;
                pass_next      = pass_reg + 2'd1;
                state_next     = S_MIX;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = S_HLOAD;
            end
            S_HLOAD:
            begin
                cmd.head_load = 1'b1;
                state_next    = S_WRD;
            end
            S_WRD:
            begin
                state_next = sts.cur_null ? S_DO : S_WCMP;
            end
            S_WCMP:
            begin
                if (sts.key_match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_DO;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_WRD;
                end
            end
            S_DO:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 2'd0;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* hdl/chme_dp.sv */
// ----------------------------------------------------------------------------
// Chained hash map engine datapath
// Hash unit, modulo unit, table memories, free stack and result register.
// ----------------------------------------------------------------------------
module chme_dp
    import chme_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic [1:0]       opcode,
    input  logic [63:0]      key,
    input  logic [31:0]      value_in,
    input  logic             rsp_ready,
    output logic             rsp_valid,
    output logic [2:0]       status,
    output logic [31:0]      value_out,
    output logic [9:0]       entries_held,
    input  chme_cmd_t        cmd,
    output chme_sts_t        sts
);

    // Item and working registers
    logic [1:0]         op_reg;
    logic [63:0]        key_reg;
    logic [31:0]        val_reg;
    logic [63:0]        x_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        acc_reg;
    logic [BKT_W-1:0]   rem_reg;
    logic [LINK_W-1:0]  cur_reg, prev_reg, head_reg, hlink_reg;
    logic [ENTRY_W-1:0] hit_reg;
    logic [31:0]        hval_reg;
    logic               found_reg;

    // Control registers
    logic [CFG_W-1:0]   bkt_reg;
    logic [MAX_BUCKETS-1:0] hvalid_reg;
    logic [LINK_W-1:0]  top_reg, top_next;
    logic [LINK_W-1:0]  low_reg;
    logic               vld_reg;
    logic [2:0]         status_reg, status_next;
    logic [31:0]        vout_reg, vout_next;
    logic [9:0]         held_reg;

    // Memory ports
    logic [LINK_W-1:0]  heads_q;
    logic [63:0]        keys_q;
    logic [31:0]        vals_q;
    logic [LINK_W-1:0]  links_q;
    logic [ENTRY_W-1:0] free_q;
    logic               links_we, heads_we;
    logic [ENTRY_W-1:0] links_waddr;
    logic [LINK_W-1:0]  links_wdata, heads_wdata;

    logic [31:0]        mul_a, mul_b;
    logic [63:0]        cst;
    logic [63:0]        prod_hi;
    logic [BKT_W-1:0]   rem_step;
    logic [BKT_W:0]     trial;
    logic [CFG_W-1:0]   cfg_clamped;
    logic [LINK_W-1:0]  head_now, top_m1;
    logic [ENTRY_W-1:0] alloc_e;
    logic               ins_ok, rem_ok;

    assign cst     = cmd.cst_sel ? MIX_C2 : MIX_C1;
    assign prod_hi = {prod_reg[31:0], 32'd0};

    // Pick the 32x32 partial product
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_HL:  begin mul_a = x_reg[63:32]; mul_b = cst[31:0];  end
            MUL_LH:  begin mul_a = x_reg[31:0];  mul_b = cst[63:32]; end
            default: begin mul_a = x_reg[31:0];  mul_b = cst[31:0];  end
        endcase
    end

    // Four restoring division steps on the top dividend nibble
    always_comb
    begin
        rem_step = rem_reg;
        trial    = '0;
        for (int i = 0; i < 4; i++)
        begin
            trial = {rem_step, x_reg[63-i]};
            if (trial >= bkt_reg)
            begin
                trial = trial - bkt_reg;
            end
            rem_step = trial[BKT_W-1:0];
        end
    end

    // Clamp the written bucket count
    always_comb
    begin
        cfg_clamped = cfg_wdata;
        if (cfg_wdata == '0)
        begin
            cfg_clamped = CFG_W'(1);
        end
        else if (cfg_wdata > CFG_W'(MAX_BUCKETS))
        begin
            cfg_clamped = CFG_W'(MAX_BUCKETS);
        end
    end

    assign head_now = hvalid_reg[rem_reg] ? heads_q : LINK_NULL;
    assign top_m1   = top_reg - LINK_W'(1);
    // Entries never pushed back come straight from the fresh pool
    assign alloc_e  = (top_m1 < low_reg) ? (ENTRY_W'(POOL_ENTRIES - 1) - top_m1[ENTRY_W-1:0])
                                          : free_q;

    assign ins_ok = (op_reg == OP_INSERT) && (val_reg != '0) && !found_reg
                    && (top_reg != '0);
    assign rem_ok = (op_reg == OP_REMOVE) && found_reg;

    // Result and write steering
    always_comb
    begin
        status_next = ST_NOT_FOUND;
        vout_next   = '0;
        top_next    = top_reg;
        links_we    = 1'b0;
        links_waddr = alloc_e;
        links_wdata = head_reg;
        heads_we    = 1'b0;
        heads_wdata = {1'b0, alloc_e};
        case (op_reg)
            OP_INSERT:
            begin
                if (val_reg == '0)
                begin
                    status_next = ST_ZERO;
                end
                else if (found_reg)
                begin
                    status_next = ST_PRESENT;
                end
                else if (top_reg == '0)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                    top_next    = top_m1;
                    links_we    = 1'b1;
                    heads_we    = 1'b1;
                end
            end
            OP_FIND:
            begin
                if (found_reg)
                begin
                    status_next = ST_OK;
                    vout_next   = hval_reg;
                end
            end
            OP_REMOVE:
            begin
                if (found_reg)
                begin
                    status_next = ST_OK;
                    vout_next   = hval_reg;
                    top_next    = top_reg + LINK_W'(1);
                    links_waddr = prev_reg[ENTRY_W-1:0];
                    links_wdata = hlink_reg;
                    heads_wdata = hlink_reg;
                    links_we    = (prev_reg != LINK_NULL);
                    heads_we    = (prev_reg == LINK_NULL);
                end
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    assign sts.cur_null  = (cur_reg == LINK_NULL);
    assign sts.key_match = (keys_q == key_reg);
    assign sts.out_free  = !vld_reg || rsp_ready;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            key_reg <= key;
            val_reg <= value_in;
            x_reg   <= key;
        end
        else if (cmd.mix)
        begin
            x_reg <= x_reg ^ (x_reg >> MIX_SHIFT);
        end
        else if (cmd.x_from_acc)
        begin
            x_reg <= acc_reg + prod_hi;
        end
        else if (cmd.div_step)
        begin
            x_reg <= {x_reg[59:0], 4'd0};
        end
        if (cmd.mul_en)
        begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        end
        if (cmd.acc_load)
        begin
            acc_reg <= prod_reg;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + prod_hi;
        end
        if (cmd.load)
        begin
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_step;
        end
        if (cmd.head_load)
        begin
            cur_reg  <= head_now;
            head_reg <= head_now;
            prev_reg <= LINK_NULL;
        end
        else if (cmd.advance)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= links_q;
        end
        if (cmd.hit)
        begin
            hit_reg   <= cur_reg[ENTRY_W-1:0];
            hval_reg  <= vals_q;
            hlink_reg <= links_q;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            vout_reg   <= vout_next;
            held_reg   <= 10'(LINK_W'(POOL_ENTRIES) - top_next);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bkt_reg    <= CFG_W'(MAX_BUCKETS);
            hvalid_reg <= '0;
            top_reg    <= LINK_W'(POOL_ENTRIES);
            low_reg    <= LINK_W'(POOL_ENTRIES);
            vld_reg    <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bkt_reg    <= cfg_clamped;
                hvalid_reg <= '0;
                top_reg    <= LINK_W'(POOL_ENTRIES);
                low_reg    <= LINK_W'(POOL_ENTRIES);
            end
            else if (cmd.commit)
            begin
                top_reg <= top_next;
                if (ins_ok && (top_m1 < low_reg))
                begin
                    low_reg <= top_m1;
                end
                if (heads_we)
                begin
                    hvalid_reg[rem_reg] <= 1'b1;
                end
            end
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.hit)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                vld_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                vld_reg <= 1'b0;
            end
        end
    end

    chme_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BUCKETS)) u_heads (
        .clk   (clk),
        .we    (cmd.commit && heads_we),
        .waddr (rem_reg),
        .wdata (heads_wdata),
        .raddr (rem_reg),
        .rdata (heads_q)
    );

    chme_ram #(.WIDTH(64), .DEPTH(POOL_ENTRIES)) u_keys (
        .clk   (clk),
        .we    (cmd.commit && ins_ok),
        .waddr (alloc_e),
        .wdata (key_reg),
        .raddr (cur_reg[ENTRY_W-1:0]),
        .rdata (keys_q)
    );

    chme_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_vals (
        .clk   (clk),
        .we    (cmd.commit && ins_ok),
        .waddr (alloc_e),
        .wdata (val_reg),
        .raddr (cur_reg[ENTRY_W-1:0]),
        .rdata (vals_q)
    );

    chme_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_links (
        .clk   (clk),
        .we    (cmd.commit && links_we),
        .waddr (links_waddr),
        .wdata (links_wdata),
        .raddr (cur_reg[ENTRY_W-1:0]),
        .rdata (links_q)
    );

    chme_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_ENTRIES)) u_free (
        .clk   (clk),
        .we    (cmd.commit && rem_ok),
        .waddr (top_reg[ENTRY_W-1:0]),
        .wdata (hit_reg),
        .raddr (top_m1[ENTRY_W-1:0]),
        .rdata (free_q)
    );

    assign rsp_valid    = vld_reg;
    assign status       = status_reg;
    assign value_out    = vout_reg;
    assign entries_held = held_reg;

endmodule

/* hdl/chained_hash_map_engine_top.sv */
// ----------------------------------------------------------------------------
// Chained hash map engine top level
// Key-value map with fmix64 bucket hashing and chained entries in a pool.
// ----------------------------------------------------------------------------
// One request at a time. After acceptance the key is hashed (its two 64-bit
// multiplies share one 32x32 multiplier, around three xor-shift steps), the
// bucket modulo runs at four quotient bits a cycle, and the bucket head is
// read. The chain walk then takes each entry through a read state, for the
// registered read of the entry memories, and a compare state; the read state
// also sees the chain end. The result is registered once the response
// channel is free, so the time per item depends on chain length. A new item
// is taken while the last result still waits on the response channel, but
// its own result is held back until that one is taken. Writing the bucket
// count clears the table at once; no clearing pass is needed.
module chained_hash_map_engine_top
    import chme_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    chme_req_if.sink         req,
    chme_rsp_if.source       rsp
);

    chme_cmd_t cmd;
    chme_sts_t sts;

    chme_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    chme_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .opcode       (req.opcode),
        .key          (req.key),
        .value_in     (req.value_in),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .status       (rsp.status),
        .value_out    (rsp.value_out),
        .entries_held (rsp.entries_held),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

/* hdl/chme_checker.sv */
// ----------------------------------------------------------------------------
// Chained hash map engine port checker
// Watches the response channel of the top level.
// ----------------------------------------------------------------------------
`include "chained_hash_map_engine_top_assert.svh"

module chme_checker
    import chme_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  status,
    input logic [31:0] value_out,
    input logic [9:0]  entries_held
);

    // Hold a stalled result
    `CHME_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(value_out), "response dropped or changed while stalled")
    // Status stays a known code
    `CHME_ASSERT_SAME(a_status_code, rsp_valid, status <= ST_ZERO, "unknown status code")
    // No value without success
    `CHME_ASSERT_SAME(a_value_zero, rsp_valid && (status != ST_OK), value_out == '0, "value returned on failure")
    // Count never exceeds the pool
    `CHME_ASSERT_SAME(a_held_range, rsp_valid, entries_held <= 10'(POOL_ENTRIES), "entry count beyond pool")

endmodule

bind chained_hash_map_engine_top chme_checker u_chme_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .value_out    (rsp.value_out),
    .entries_held (rsp.entries_held)
);
